// File: design/lsq_pkg.sv
package lsq_pkg;

  // Line buffer and frame geometry
  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int CNT_W       = COL_W + 1;

  // Fixed field widths of the interface
  localparam int CFG_W       = 11;
  localparam int SIZE_W      = 11;
  localparam int OUT_ROW_W   = 10;
  localparam int OUT_COL_W   = 10;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;
  localparam int CMP_W       = (CFG_W > CNT_W) ? CFG_W : CNT_W;

  localparam logic [CFG_W-1:0]  ROW_WIDTH_RESET = CFG_W'(6);
  localparam logic [SIZE_W-1:0] SIZE_SAT        = '1;

  // Depth of the queue between the front and the back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified cell on its way to the back
  typedef struct packed {
    logic             pixel;
    logic             last;
    logic             first;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } lsq_entry_t;

endpackage

// File: design/lsq_ram.sv
module lsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, read one entry registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/lsq_front.sv
module lsq_front import lsq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  cell_i,
  input  logic                  last_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output lsq_entry_t            entry_o
);

  logic [CFG_W-1:0] row_width_q;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [CMP_W-1:0] width_raw;
  logic [CMP_W-1:0] width_eff;
  logic [CMP_W-1:0] col_next;
  logic             row_end;
  logic             accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Clamp the programmed width into 1..MAX_COLUMNS
  assign width_raw = CMP_W'(row_width_q);
  always_comb begin
    if (width_raw == '0) begin
      width_eff = CMP_W'(1);
    end else if (width_raw > CMP_W'(MAX_COLUMNS)) begin
      width_eff = CMP_W'(MAX_COLUMNS);
    end else begin
      width_eff = width_raw;
    end
  end

  assign col_next = CMP_W'(col_q) + CMP_W'(1);
  assign row_end  = (col_next >= width_eff);

  // Advance the raster position, wrap at row end, saturate the row, restart after the last cell
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_i) begin
        col_d = '0;
        row_d = '0;
      end else if (row_end) begin
        col_d = '0;
        if (row_q < ROW_W'(MAX_ROWS - 1)) begin
          row_d = row_q + ROW_W'(1);
        end
      end else begin
        col_d = col_next[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= ROW_WIDTH_RESET;
      col_q       <= '0;
      row_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        row_width_q <= cfg_wdata_i;
      end
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Classify the item for the back
  assign push_o        = accept;
  assign entry_o.pixel = cell_i;
  assign entry_o.last  = last_i;
  assign entry_o.first = (row_q == '0) || (col_q == '0);
  assign entry_o.row   = row_q;
  assign entry_o.col   = col_q;

endmodule

// File: design/lsq_queue.sv
module lsq_queue import lsq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  lsq_entry_t entry_i,
  output logic       full_o,
  output logic       valid_o,
  input  logic       pop_i,
  output lsq_entry_t entry_o
);

  lsq_entry_t        slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = slot_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  // Move the pointers and the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (do_pop && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

endmodule

// File: design/lsq_back.sv
module lsq_back import lsq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  lsq_entry_t            q_entry_i,
  output logic                  pop_o,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output logic [OUT_ROW_W-1:0]  res_row_o,
  output logic [OUT_COL_W-1:0]  res_col_o,
  output logic [SIZE_W-1:0]     res_size_o
);

  lsq_entry_t        s1_q;
  logic              s1_valid_q;
  logic              fire;
  logic [COL_W-1:0]  raddr;
  logic [SIZE_W-1:0] rdata;
  logic              byp_q;
  logic [SIZE_W-1:0] byp_data_q;
  logic [SIZE_W-1:0] up;
  logic [SIZE_W-1:0] left_q;
  logic [SIZE_W-1:0] diag_q;
  logic [SIZE_W-1:0] min_ul;
  logic [SIZE_W-1:0] min3;
  logic [SIZE_W-1:0] size;
  logic              better;
  logic [SIZE_W-1:0] best_size_q;
  logic [ROW_W-1:0]  best_row_q;
  logic [COL_W-1:0]  best_col_q;
  logic              res_valid_q;
  logic [OUT_ROW_W-1:0] res_row_q;
  logic [OUT_COL_W-1:0] res_col_q;
  logic [SIZE_W-1:0]    res_size_q;

  // Compute stage goes ahead unless a result would overwrite an untaken one
  assign fire  = s1_valid_q && (!s1_q.last || !res_valid_q || res_ready_i);
  assign pop_o = q_valid_i && (!s1_valid_q || fire);

  // Read the line buffer for the next item, or hold the address while stalled
  assign raddr = pop_o ? q_entry_i.col : s1_q.col;

  lsq_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (MAX_COLUMNS)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (fire),
    .waddr_i (s1_q.col),
    .wdata_i (size),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Take a value written in the same cycle as its read
  assign up = byp_q ? byp_data_q : rdata;

  // Side of the square ending at this cell
  assign min_ul = (up < left_q) ? up : left_q;
  assign min3   = (min_ul < diag_q) ? min_ul : diag_q;
  always_comb begin
    if (!s1_q.pixel) begin
      size = '0;
    end else if (s1_q.first) begin
      size = SIZE_W'(1);
    end else if (min3 == SIZE_SAT) begin
      size = SIZE_SAT;
    end else begin
      size = min3 + SIZE_W'(1);
    end
  end

  assign better = (size > best_size_q);

  // Payload of the compute stage and the neighbour values
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_q <= q_entry_i;
    end
    byp_data_q <= size;
    if (fire) begin
      left_q <= size;
      diag_q <= up;
    end
    if (fire && s1_q.last) begin
      res_row_q  <= OUT_ROW_W'(better ? s1_q.row : best_row_q);
      res_col_q  <= OUT_COL_W'(better ? s1_q.col : best_col_q);
      res_size_q <= better ? size : best_size_q;
    end
  end

  // Control, running best and result hand-off
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      byp_q       <= 1'b0;
      best_size_q <= '0;
      best_row_q  <= '0;
      best_col_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        s1_valid_q <= 1'b1;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      byp_q <= fire && (raddr == s1_q.col);
      if (fire) begin
        if (s1_q.last) begin
          best_size_q <= '0;
          best_row_q  <= '0;
          best_col_q  <= '0;
        end else if (better) begin
          best_size_q <= size;
          best_row_q  <= s1_q.row;
          best_col_q  <= s1_q.col;
        end
      end
      if (fire && s1_q.last) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_row_o   = res_row_q;
  assign res_col_o   = res_col_q;
  assign res_size_o  = res_size_q;

endmodule

// File: design/largest_square_of_ones.sv
// Largest all-ones square in a binary matrix streamed in raster order.
// Input stream: one cell per item, tdata bit 0 is the cell value, tlast
// marks the final cell of the matrix. Output stream: one item per matrix,
// sent after the last cell, carrying the side of the largest square and
// the row and column of its bottom-right corner (first one in raster
// order on ties; size 0 at row 0, column 0 for an all-zero matrix).
// cfg_we_i/cfg_wdata_i set the row width; write it only while idle.
// Throughput: one cell per cycle unless a last cell waits for a stalled
// receiver, set by the line buffer's read-modify-write of one entry per
// cell, with a bypass for back-to-back accesses. The last cell passes the
// queue and then the compute stage, and its result is registered.
// A two-item queue separates input classification from the compute stage,
// so input keeps flowing while a result waits; if the receiver stalls,
// cells continue up to the next last cell, which then waits for the
// result slot, and the input backs up once the queue fills.
// Reset: row width 6, position and running best cleared, no clearing
// pass on the line buffer, ready as soon as reset is released.
module largest_square_of_ones import lsq_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [0] cell_req, rest zero
  input  logic                   s_axis_tlast,  // last_cell
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // [9:0] best_row, [19:10] best_column,
                                                // [30:20] best_size, [31] zero
);

  logic                 q_full;
  logic                 push;
  lsq_entry_t           push_entry;
  logic                 q_valid;
  lsq_entry_t           q_entry;
  logic                 pop;
  logic [OUT_ROW_W-1:0] best_row;
  logic [OUT_COL_W-1:0] best_column;
  logic [SIZE_W-1:0]    best_size;

  lsq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cell_i      (s_axis_tdata[0]),
    .last_i      (s_axis_tlast),
    .q_full_i    (q_full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  lsq_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .entry_o (q_entry)
  );

  lsq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .pop_o       (pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_row_o   (best_row),
    .res_col_o   (best_column),
    .res_size_o  (best_size)
  );

  // Pack the result fields, lowest field first
  assign m_axis_tdata = OUT_TDATA_W'({best_size, best_column, best_row});

endmodule
